// File: rtl/ele_pkg.sv
// Shared constants for the echoing line editor.
// Character codes and size defaults; used by the top level and its port checker.
// No dependencies.
`default_nettype none

package ele_pkg;

	// default store depth in bytes
	localparam int DEF_LINE_DEPTH = 256;

	// configuration register width and its value after reset
	localparam int LIMIT_W = 9;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd128;

	// character codes
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_DEL = 8'h7f;

	// request kinds on the input tuser bit
	localparam logic REQ_CHAR = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// output bus layout
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 2;

endpackage

`default_nettype wire

// File: rtl/echoing_line_editor.sv
// Echoing line editor: top level with line store, cursor and result sequencer.
// Depends on ele_pkg.
//
// Usage
//   s_* channel: one request per accepted beat. s_tuser selects a received
//   character (0) or a read of a stored line byte (1).
//   m_* channel: one echo or read result per beat; m_tlast marks the final
//   result of a request. A character gives zero to three results (CR/LF two,
//   erase three), a read always one.
//   cfg_* channel: writes line_limit; always ready. Write only while idle.
// Flow: a request is captured in the input register, is processed as it
//   leaves it, and its first result is then driven on m_* by the result holder.
// Throughput: one result per cycle while m_tready is high, set by the single
//   result port. A new request is taken in the same cycle the last result of
//   the previous one is taken.
// Reset: cursor and completed length clear, line_limit becomes 128, no result
//   pending. The line store is not cleared; only written bytes are ever read.
// Stall: while m_tready is low the result holder keeps its result, the input
//   register fills, and then s_tready drops until the holder drains.
`default_nettype none

module echoing_line_editor #(
	parameter int LINE_DEPTH = ele_pkg::DEF_LINE_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// request stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [15:0]                     s_tdata,  // char_in[7:0], read_index[15:8]
	input  wire logic                            s_tuser,  // req_type
	// result stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [ele_pkg::OUT_DATA_W-1:0]       m_tdata,  // echo_byte, line_length, read_data
	output logic [ele_pkg::OUT_USER_W-1:0]       m_tuser,  // echo_valid, line_done
	output logic                                 m_tlast,
	// configuration write
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ele_pkg::LIMIT_W-1:0]     cfg_data
);
	import ele_pkg::*;

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int CW = (AW > 8) ? AW : 8;
	localparam int LW_D = $clog2(LINE_DEPTH + 1);
	localparam int LW = (LW_D > LIMIT_W) ? LW_D : LIMIT_W;

	// result kinds held in the result holder
	localparam logic [1:0] K_READ    = 2'd0;
	localparam logic [1:0] K_PRINT   = 2'd1;
	localparam logic [1:0] K_NEWLINE = 2'd2;
	localparam logic [1:0] K_ERASE   = 2'd3;

	// result positions within one request
	localparam logic [1:0] R_FIRST  = 2'd0;
	localparam logic [1:0] R_SECOND = 2'd1;
	localparam logic [1:0] R_THIRD  = 2'd2;

	logic [LIMIT_W-1:0] line_limit_q;
	logic [AW-1:0]      cursor_q;
	logic [AW-1:0]      completed_q;

	logic               valid_s1;
	logic               req_s1;
	logic [7:0]         char_s1;
	logic [7:0]         ridx_s1;
	logic [7:0]         rdata_s1;

	logic               busy_q;
	logic [1:0]         kind_q;
	logic [1:0]         pos_q;
	logic [7:0]         pay_q;

	logic [7:0]         line_mem [LINE_DEPTH];

	logic               accept;
	logic               hold_free;
	logic               advance;
	logic               out_last;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			line_limit_q <= cfg_data;
		end
	end

	// handshake: the input register moves on once the holder is free
	assign hold_free = !busy_q || (m_tready && out_last);
	assign advance   = valid_s1 && hold_free;
	assign s_tready  = !valid_s1 || hold_free;
	assign accept    = s_tvalid && s_tready;

	// decode of the item in the input register
	logic               is_nl;
	logic               is_bs;
	logic               is_print;
	logic [LW-1:0]      limit_eff;
	logic               room;
	logic               do_read;
	logic               do_nl;
	logic               do_erase;
	logic               do_print;
	logic               mem_we;
	logic [7:0]         mem_wdata;
	logic [CW-1:0]      ridx_ext;
	logic [CW-1:0]      cursor_ext;
	logic [7:0]         read_byte;

	always_comb begin
		is_nl     = (char_s1 == CH_CR) || (char_s1 == CH_LF);
		is_bs     = (char_s1 == CH_BS) || (char_s1 == CH_DEL);
		is_print  = (char_s1 >= CH_SP) && (char_s1 < CH_DEL);
		limit_eff = (LW'(line_limit_q) > LW'(LINE_DEPTH)) ? LW'(LINE_DEPTH)
			: LW'(line_limit_q);
		room      = (LW'(cursor_q) + LW'(1)) < limit_eff;

		do_read   = advance && (req_s1 == REQ_READ);
		do_nl     = advance && (req_s1 == REQ_CHAR) && is_nl;
		do_erase  = advance && (req_s1 == REQ_CHAR) && is_bs && (cursor_q != '0);
		do_print  = advance && (req_s1 == REQ_CHAR) && is_print && room;

		mem_we    = do_nl || do_print;
		mem_wdata = do_print ? char_s1 : CH_NUL;

		ridx_ext   = CW'(ridx_s1);
		cursor_ext = CW'(cursor_q);
		read_byte  = (ridx_ext < CW'(completed_q)) ? rdata_s1 : CH_NUL;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= s_tuser;
			char_s1 <= s_tdata[7:0];
			ridx_s1 <= s_tdata[15:8];
		end
	end

	// line store: written by the item leaving the input register, read at
	// acceptance; a write in the same cycle to the same entry is forwarded
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] rd_ext;

	always_comb begin
		rd_ext  = CW'(s_tdata[15:8]);
		rd_addr = rd_ext[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[cursor_q] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (mem_we && (rd_addr == cursor_q)) begin
				rdata_s1 <= mem_wdata;
			end else begin
				rdata_s1 <= line_mem[rd_addr];
			end
		end
	end

	// cursor and completed line length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			completed_q <= '0;
		end else begin
			if (do_nl) begin
				completed_q <= cursor_q;
				cursor_q    <= '0;
			end else if (do_erase) begin
				cursor_q <= cursor_q - AW'(1);
			end else if (do_print) begin
				cursor_q <= cursor_q + AW'(1);
			end
		end
	end

	// result holder: kind, position and one payload byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= R_FIRST;
			kind_q <= K_READ;
		end else if (hold_free) begin
			busy_q <= do_read || do_nl || do_erase || do_print;
			pos_q  <= R_FIRST;
			if (do_read) begin
				kind_q <= K_READ;
			end else if (do_nl) begin
				kind_q <= K_NEWLINE;
			end else if (do_erase) begin
				kind_q <= K_ERASE;
			end else begin
				kind_q <= K_PRINT;
			end
		end else if (m_tready) begin
			pos_q <= pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (hold_free) begin
			if (do_read) begin
				pay_q <= read_byte;
			end else if (do_nl) begin
				pay_q <= cursor_ext[7:0];
			end else begin
				pay_q <= char_s1;
			end
		end
	end

	// result fields from the holder
	logic       echo_valid;
	logic [7:0] echo_byte;
	logic       line_done;
	logic [7:0] line_length;
	logic [7:0] read_data;

	always_comb begin
		echo_valid  = 1'b1;
		echo_byte   = CH_NUL;
		line_done   = 1'b0;
		line_length = 8'd0;
		read_data   = 8'd0;
		out_last    = 1'b0;
		case (kind_q)
			K_READ: begin
				echo_valid = 1'b0;
				read_data  = pay_q;
				out_last   = 1'b1;
			end
			K_PRINT: begin
				echo_byte = pay_q;
				out_last  = 1'b1;
			end
			K_NEWLINE: begin
				if (pos_q == R_FIRST) begin
					echo_byte = CH_CR;
				end else begin
					echo_byte   = CH_LF;
					line_done   = 1'b1;
					line_length = pay_q;
					out_last    = 1'b1;
				end
			end
			K_ERASE: begin
				echo_byte = (pos_q == R_SECOND) ? CH_SP : CH_BS;
				out_last  = (pos_q == R_THIRD);
			end
			default: begin
				out_last = 1'b1;
			end
		endcase
	end

	assign m_tvalid = busy_q;
	assign m_tdata  = {read_data, line_length, echo_byte};
	assign m_tuser  = {line_done, echo_valid};
	assign m_tlast  = out_last;

endmodule

`default_nettype wire

// File: rtl/ele_checker.sv
// Port checker for the echoing line editor result stream, with its bind.
// Depends on ele_pkg; attaches to echoing_line_editor.
`default_nettype none

module ele_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            m_tvalid,
	input  wire logic                            m_tready,
	input  wire logic [ele_pkg::OUT_DATA_W-1:0]  m_tdata,  // echo_byte, line_length, read_data
	input  wire logic [ele_pkg::OUT_USER_W-1:0]  m_tuser,  // echo_valid, line_done
	input  wire logic                            m_tlast
);
	import ele_pkg::*;

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// line completion is the LF echo and ends the request
	a_done_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && m_tuser[0] && (m_tdata[7:0] == CH_LF))
		else $error("line done not on final LF");

	// a read result carries no echo and stands alone
	a_read_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && !m_tuser[1] && (m_tdata[7:0] == CH_NUL)
			&& (m_tdata[15:8] == 8'd0))
		else $error("malformed read result");

	// CR echo is followed directly by the LF echo
	a_cr_then_lf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser[0] && !m_tlast && (m_tdata[7:0] == CH_CR)
		|=> m_tvalid && m_tuser[0] && (m_tdata[7:0] == CH_LF))
		else $error("CR echo not followed by LF");

endmodule

bind echoing_line_editor ele_checker u_ele_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
